// ===== hdl/rect_blit_pixel_double_top_macros.svh =====
// Assertion macros shared by the blitter modules.
`ifndef RECT_BLIT_PIXEL_DOUBLE_TOP_MACROS_SVH
`define RECT_BLIT_PIXEL_DOUBLE_TOP_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define RBPD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define RBPD_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define RBPD_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== hdl/rbpd_pkg.sv =====
// Shared types and constants of the pixel-double rectangle blitter.
`default_nettype none

package rbpd_pkg;

  localparam int unsigned COORD_BITS_DEF = 11;
  localparam int unsigned DEST_W         = 11;
  localparam int unsigned SIZE_W         = 12;
  localparam int unsigned COLOR_W        = 8;
  localparam int unsigned ADDR_W         = 23;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 12;
  localparam int unsigned S_TDATA_W      = 16;
  localparam int unsigned M_TDATA_W      = 32;
  localparam int unsigned QDEPTH         = 2;
  localparam int unsigned QPTR_W         = $clog2(QDEPTH);
  localparam int unsigned QCNT_W         = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    MODE_COPY   = 2'd0,
    MODE_BRUSH  = 2'd1,
    MODE_MONO   = 2'd2,
    MODE_INVERT = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE         = 3'd0,
    CFG_DEST_X       = 3'd1,
    CFG_DEST_Y       = 3'd2,
    CFG_RECT_WIDTH   = 3'd3,
    CFG_RECT_HEIGHT  = 3'd4,
    CFG_SCREEN_WIDTH = 3'd5,
    CFG_TRANSP_COLOR = 3'd6,
    CFG_MONO_COLOR   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    mode_e               mode;
    logic [DEST_W-1:0]   dest_x;
    logic [DEST_W-1:0]   dest_y;
    logic [SIZE_W-1:0]   rect_width;
    logic [SIZE_W-1:0]   rect_height;
    logic [SIZE_W-1:0]   screen_width;
    logic [COLOR_W-1:0]  transparent_color;
    logic [COLOR_W-1:0]  mono_color;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/rbpd_cfg.sv =====
// Configuration register file of the blitter.
`default_nettype none

module rbpd_cfg
  import rbpd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:         cfg_d.mode              = mode_e'(cfg_data_i[1:0]);
        CFG_DEST_X:       cfg_d.dest_x            = cfg_data_i[DEST_W-1:0];
        CFG_DEST_Y:       cfg_d.dest_y            = cfg_data_i[DEST_W-1:0];
        CFG_RECT_WIDTH:   cfg_d.rect_width        = cfg_data_i[SIZE_W-1:0];
        CFG_RECT_HEIGHT:  cfg_d.rect_height       = cfg_data_i[SIZE_W-1:0];
        CFG_SCREEN_WIDTH: cfg_d.screen_width      = cfg_data_i[SIZE_W-1:0];
        CFG_TRANSP_COLOR: cfg_d.transparent_color = cfg_data_i[COLOR_W-1:0];
        CFG_MONO_COLOR:   cfg_d.mono_color        = cfg_data_i[COLOR_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode              <= MODE_COPY;
      cfg_q.dest_x            <= '0;
      cfg_q.dest_y            <= '0;
      cfg_q.rect_width        <= SIZE_W'(1);
      cfg_q.rect_height       <= SIZE_W'(1);
      cfg_q.screen_width      <= SIZE_W'(1);
      cfg_q.transparent_color <= '0;
      cfg_q.mono_color        <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/rbpd_front.sv =====
// Front end: accepts pixels, steps the raster counters and resolves the mode.
`default_nettype none
`include "rect_blit_pixel_double_top_macros.svh"

module rbpd_front
  import rbpd_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned XW         = ((COORD_BITS > DEST_W) ? COORD_BITS : DEST_W) + 1,
  parameter int unsigned ENTRY_W    = 2 * XW + COLOR_W + 2
)
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  cfg_t                      cfg_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [COLOR_W-1:0]   src_pixel_i,
  input  wire logic [COLOR_W-1:0]   dest_pixel_i,
  output logic                      push_valid_o,
  input  wire logic                 push_ready_i,
  output logic [ENTRY_W-1:0]        push_data_o
);

  localparam int unsigned CW = ((COORD_BITS + 1) > SIZE_W) ? (COORD_BITS + 1) : SIZE_W;
  localparam logic [CW-1:0] SPAN = CW'(1) << COORD_BITS;

  logic [COORD_BITS-1:0] col_q, col_d;
  logic [COORD_BITS-1:0] row_q, row_d;
  logic [COORD_BITS:0]   col_inc;
  logic [COORD_BITS:0]   row_inc;
  logic [CW-1:0]         w_ext, h_ext, w_eff, h_eff;
  logic                  row_end, rect_end;
  logic                  fire;
  logic [XW-1:0]         x_pos, y_pos;
  logic [COLOR_W-1:0]    value;
  logic                  we;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign fire         = in_valid_i && push_ready_i;

  assign col_inc = (COORD_BITS + 1)'(col_q) + (COORD_BITS + 1)'(1);
  assign row_inc = (COORD_BITS + 1)'(row_q) + (COORD_BITS + 1)'(1);
  assign w_ext   = CW'(cfg_i.rect_width);
  assign h_ext   = CW'(cfg_i.rect_height);

  always_comb begin
    if (w_ext == '0) begin
      w_eff = CW'(1);
    end else if (w_ext > SPAN) begin
      w_eff = SPAN;
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = CW'(1);
    end else if (h_ext > SPAN) begin
      h_eff = SPAN;
    end else begin
      h_eff = h_ext;
    end
  end

  assign row_end  = CW'(col_inc) >= w_eff;
  assign rect_end = row_end && (CW'(row_inc) >= h_eff);

  assign x_pos = XW'(cfg_i.dest_x) + XW'(col_q);
  assign y_pos = XW'(cfg_i.dest_y) + XW'(row_q);

  always_comb begin
    unique case (cfg_i.mode)
      MODE_BRUSH: begin
        we    = src_pixel_i != cfg_i.transparent_color;
        value = we ? src_pixel_i : '0;
      end
      MODE_MONO: begin
        we    = src_pixel_i != cfg_i.transparent_color;
        value = we ? cfg_i.mono_color : '0;
      end
      MODE_INVERT: begin
        we    = 1'b1;
        value = ~dest_pixel_i;
      end
      default: begin
        we    = 1'b1;
        value = src_pixel_i;
      end
    endcase
  end

  assign push_data_o = {rect_end, we, value, y_pos, x_pos};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (fire) begin
      if (rect_end) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_inc[COORD_BITS-1:0];
      end else begin
        col_d = col_inc[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  `RBPD_ASSERT_NEXT(a_rect_wrap, clk_i, rst_ni, fire && rect_end, col_q == '0 && row_q == '0)

endmodule

`default_nettype wire

// ===== hdl/rbpd_fifo.sv =====
// Short queue between the front and back ends.
`default_nettype none
`include "rect_blit_pixel_double_top_macros.svh"

module rbpd_fifo
  import rbpd_pkg::*;
#(
  parameter int unsigned DATA_W = 32
)
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire logic [DATA_W-1:0] push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output logic [DATA_W-1:0]      pop_data_o
);

  logic [DATA_W-1:0] mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = cnt_q != QCNT_W'(QDEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `RBPD_ASSERT_ALWAYS(a_cnt_range, clk_i, rst_ni, cnt_q <= QCNT_W'(QDEPTH))

endmodule

`default_nettype wire

// ===== hdl/rbpd_back.sv =====
// Back end: computes the pair address in two stages and holds the result.
`default_nettype none
`include "rect_blit_pixel_double_top_macros.svh"

module rbpd_back
  import rbpd_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned XW         = ((COORD_BITS > DEST_W) ? COORD_BITS : DEST_W) + 1,
  parameter int unsigned ENTRY_W    = 2 * XW + COLOR_W + 2
)
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [SIZE_W-1:0]  screen_width_i,
  input  wire logic               pop_valid_i,
  output logic                    pop_ready_o,
  input  wire logic [ENTRY_W-1:0] pop_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [ADDR_W-1:0]       byte_address_o,
  output logic [COLOR_W-1:0]      pixel_value_o,
  output logic                    write_enable_o,
  output logic                    last_o
);

  localparam int unsigned PW = XW + SIZE_W;

  logic [XW-1:0]       e_x, e_y;
  logic [COLOR_W-1:0]  e_value;
  logic                e_we, e_last;

  logic                s1_valid_q;
  logic [PW-1:0]       s1_prod_q;
  logic [XW-1:0]       s1_x_q;
  logic [COLOR_W-1:0]  s1_value_q;
  logic                s1_we_q, s1_last_q;

  logic                out_valid_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic [COLOR_W-1:0]  out_value_q;
  logic                out_we_q, out_last_q;

  logic                out_ready, s1_ready, s1_load, out_load;
  logic [ADDR_W-2:0]   addr_half;

  assign {e_last, e_we, e_value, e_y, e_x} = pop_data_i;

  assign out_ready   = !out_valid_q || out_ready_i;
  assign s1_ready    = !s1_valid_q || out_ready;
  assign pop_ready_o = s1_ready;
  assign s1_load     = pop_valid_i && s1_ready;
  assign out_load    = s1_valid_q && out_ready;

  assign addr_half = s1_prod_q[ADDR_W-2:0] + (ADDR_W - 1)'(s1_x_q);

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_prod_q  <= PW'(e_y) * PW'(screen_width_i);
      s1_x_q     <= e_x;
      s1_value_q <= e_value;
      s1_we_q    <= e_we;
      s1_last_q  <= e_last;
    end
    if (out_load) begin
      out_addr_q  <= {addr_half, 1'b0};
      out_value_q <= s1_value_q;
      out_we_q    <= s1_we_q;
      out_last_q  <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= pop_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_address_o = out_addr_q;
  assign pixel_value_o  = out_value_q;
  assign write_enable_o = out_we_q;
  assign last_o         = out_last_q;

  `RBPD_ASSERT_IMPL(a_skip_zero, clk_i, rst_ni, out_valid_q && !out_we_q, out_value_q == '0)
  `RBPD_ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !out_ready, s1_valid_q && $stable(s1_x_q) && $stable(s1_prod_q))

endmodule

`default_nettype wire

// ===== hdl/rect_blit_pixel_double_top.sv =====
// Pixel-double rectangle blitter: one write result for every source pixel.
// Throughput: one pixel per cycle, sustained while the output side is ready.
// Each result is registered in a queue entry, then in the address multiply stage,
// then in the output register, from which it is presented.
// A two-entry queue decouples input acceptance from output stalls.
// Reset: counters at the top-left, queue and pipeline empty, registers at defaults.
`default_nettype none

module rect_blit_pixel_double_top
  import rbpd_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
)
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [7:0] src_pixel, [15:8] dest_pixel
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [22:0] byte_address, [30:23] pixel_value, [31] zero
  output logic [M_TDATA_W-1:0]       m_axis_tdata,
  // [0] write_enable
  output logic                       m_axis_tuser,
  output logic                       m_axis_tlast
);

  localparam int unsigned XW      = ((COORD_BITS > DEST_W) ? COORD_BITS : DEST_W) + 1;
  localparam int unsigned ENTRY_W = 2 * XW + COLOR_W + 2;

  cfg_t               cfg;
  logic               push_valid, push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop_valid, pop_ready;
  logic [ENTRY_W-1:0] pop_data;
  logic [ADDR_W-1:0]  byte_address;
  logic [COLOR_W-1:0] pixel_value;

  rbpd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rbpd_front #(
    .COORD_BITS (COORD_BITS),
    .XW         (XW),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .src_pixel_i  (s_axis_tdata[COLOR_W-1:0]),
    .dest_pixel_i (s_axis_tdata[2*COLOR_W-1:COLOR_W]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  rbpd_fifo #(
    .DATA_W (ENTRY_W)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rbpd_back #(
    .COORD_BITS (COORD_BITS),
    .XW         (XW),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .screen_width_i (cfg.screen_width),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_data_i     (pop_data),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .byte_address_o (byte_address),
    .pixel_value_o  (pixel_value),
    .write_enable_o (m_axis_tuser),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, pixel_value, byte_address};

endmodule

`default_nettype wire
